@@ hdl/oaht_pkg.sv @@
// ============================================================================
// oaht_pkg: shared types and codes for the open-address hash table unit
// Holds request and status codes, slot marks and the request record that
// travels from the front end to the probe engine.
// ============================================================================
`default_nettype none

package oaht_pkg;

    localparam logic [1:0] OP_SEARCH = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FAILED   = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;
    localparam logic [2:0] ST_DELETED  = 3'd5;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED  = 2'd1;
    localparam logic [1:0] MARK_GONE  = 2'd2;

    localparam logic [1:0] REG_SIZE       = 2'd0;
    localparam logic [1:0] REG_PROBE_MODE = 2'd1;

    localparam int unsigned REQ_KEY_MAX  = 64;
    localparam int unsigned REQ_DATA_MAX = 64;

    // request after classification; widths are the widest the unit supports
    typedef struct packed {
        logic [1:0]              op;
        logic [REQ_KEY_MAX-1:0]  key;
        logic [REQ_DATA_MAX-1:0] data;
        logic [15:0]             home;
        logic [15:0]             step;
    } req_t;

endpackage

`default_nettype wire

@@ hdl/oaht_front.sv @@
// ============================================================================
// oaht_front: request front end
// Reduces home slot and step modulo the live table size (one subtract per
// cycle for both) and pushes the request into a short queue.
// ============================================================================
`default_nettype none

module oaht_front #(
    parameter int SLOTS = 1024,
    parameter int KEY_BITS = 64,
    parameter int DATA_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           op,
    input  wire logic [KEY_BITS-1:0]  key,
    input  wire logic [DATA_BITS-1:0] data_in,
    input  wire logic [9:0]           home_slot,
    input  wire logic [9:0]           probe_step,
    input  wire logic [16:0]          size,
    input  wire logic                 mode,
    output oaht_pkg::req_t            q_data,
    output logic                      q_valid,
    input  wire logic                 q_pop
);
    localparam int QD = 2;

    oaht_pkg::req_t  work_reg, work_next;
    logic            busy_reg, busy_next;
    logic [16:0]     hrem, srem;
    logic            hdone, sdone;
    oaht_pkg::req_t  fifo_reg [QD];
    logic [1:0]      cnt_reg;
    logic            rd_reg, wr_reg;
    logic            enq;
    oaht_pkg::req_t  enq_data;

    assign hrem  = {1'b0, work_reg.home} - size;
    assign srem  = {1'b0, work_reg.step} - size;
    assign hdone = {1'b0, work_reg.home} < size;
    assign sdone = {1'b0, work_reg.step} < size;
    assign enq   = busy_reg && hdone && sdone && (cnt_reg != 2'(QD));
    assign full  = busy_reg;

    always_comb
    begin
        work_next = work_reg;
        busy_next = busy_reg;
        if (!busy_reg)
        begin
            if (push)
            begin
                busy_next = 1'b1;
                work_next.op   = op;
                work_next.key  = 64'(key);
                work_next.data = 64'(data_in);
                work_next.home = 16'(home_slot);
                work_next.step = mode ? 16'(probe_step) : 16'd1;
            end
        end
        else
        begin
            if (!hdone) work_next.home = hrem[15:0];
            if (!sdone) work_next.step = srem[15:0];
            if (enq)
            begin
                busy_next = 1'b0;
                if (work_reg.step == 16'd0) work_next.step = 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    // zero step becomes one on the way into the queue
    always_comb
    begin
        enq_data = work_reg;
        if (work_reg.step == 16'd0) enq_data.step = 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (enq) wr_reg <= ~wr_reg;
            if (q_pop && q_valid) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(enq) - 2'(q_pop && q_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq) fifo_reg[wr_reg] <= enq_data;
    end

    assign q_valid = cnt_reg != 2'd0;
    assign q_data  = fifo_reg[rd_reg];
endmodule

`default_nettype wire

@@ hdl/oaht_engine.sv @@
// ============================================================================
// oaht_engine: probe engine
// Walks the probe sequence one slot at a time (read, then decide) over
// the mark, key and data memories and writes one result beat.
// ============================================================================
`default_nettype none

module oaht_engine #(
    parameter int SLOTS = 1024,
    parameter int KEY_BITS = 64,
    parameter int DATA_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [16:0]           size,
    input  wire oaht_pkg::req_t        q_data,
    input  wire logic                  q_valid,
    output logic                       q_pop,
    output logic                       res_valid,
    input  wire logic                  res_take,
    output logic [2:0]                 res_status,
    output logic [DATA_BITS-1:0]       res_data,
    output logic [10:0]                res_probes,
    output logic [9:0]                 res_count,
    output logic                       clearing
);
    localparam int AW = $clog2(SLOTS);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [1:0]           mark_mem [SLOTS];
    logic [KEY_BITS-1:0]  key_mem  [SLOTS];
    logic [DATA_BITS-1:0] data_mem [SLOTS];

    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        idx_reg, idx_next, home_reg;
    logic [16:0]          step_reg;
    logic [1:0]           op_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [DATA_BITS-1:0] din_reg;
    logic                 gone_reg, gone_next;
    logic [AW-1:0]        first_reg, first_next;
    logic [16:0]          probes_reg, probes_next;
    logic [16:0]          occ_reg, occ_next;
    logic [2:0]           st_reg, st_next;
    logic [DATA_BITS-1:0] dout_reg, dout_next;
    logic [1:0]           m_rd;
    logic [KEY_BITS-1:0]  k_rd;
    logic [DATA_BITS-1:0] d_rd;
    logic                 full_reg;

    logic                 mark_we, kd_we, data_we;
    logic [AW-1:0]        w_addr, w_kaddr;
    logic [1:0]           w_mark;

    logic [16:0]          idx_dn;
    logic [AW-1:0]        idx_wrap;
    logic                 is_ins;

    assign is_ins = op_reg == oaht_pkg::OP_INSERT;
    assign idx_dn = {{(17-AW){1'b0}}, idx_reg} - step_reg;
    assign idx_wrap = idx_dn[16] ? AW'(idx_dn + size) : AW'(idx_dn);

    always_ff @(posedge clk)
    begin
        m_rd <= mark_mem[idx_reg];
        k_rd <= key_mem[idx_reg];
        d_rd <= data_mem[idx_reg];
        if (mark_we) mark_mem[w_addr] <= w_mark;
        if (kd_we) key_mem[w_kaddr] <= key_reg;
        if (data_we) data_mem[w_kaddr] <= din_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        gone_next   = gone_reg;
        first_next  = first_reg;
        probes_next = probes_reg;
        occ_next    = occ_reg;
        st_next     = st_reg;
        dout_next   = dout_reg;
        q_pop       = 1'b0;
        mark_we     = 1'b0;
        kd_we       = 1'b0;
        data_we     = 1'b0;
        w_addr      = idx_reg;
        w_kaddr     = idx_reg;
        w_mark      = oaht_pkg::MARK_EMPTY;
        unique case (state_reg)
            S_CLR:
            begin
                mark_we = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == AW'(SLOTS - 1)) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    idx_next    = AW'(q_data.home);
                    gone_next   = 1'b0;
                    probes_next = 17'd0;
                    dout_next   = '0;
                    st_next     = (q_data.op == oaht_pkg::OP_INSERT) ?
                                  oaht_pkg::ST_FAILED : oaht_pkg::ST_MISSING;
                    state_next  = (q_data.op == oaht_pkg::OP_NONE) ? S_OUT : S_RD;
                end
            end
            S_RD:
            begin
                probes_next = probes_reg + 17'd1;
                state_next  = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_OUT;
                if (m_rd == oaht_pkg::MARK_EMPTY)
                begin
                    if (is_ins && (!full_reg || gone_reg))
                    begin
                        mark_we = 1'b1;
                        kd_we   = 1'b1;
                        data_we = 1'b1;
                        w_addr  = gone_reg ? first_reg : idx_reg;
                        w_kaddr = w_addr;
                        w_mark  = oaht_pkg::MARK_USED;
                        occ_next = occ_reg + 17'd1;
                        st_next = oaht_pkg::ST_INSERTED;
                    end
                end
                else if (m_rd == oaht_pkg::MARK_USED && k_rd == key_reg)
                begin
                    priority if (is_ins)
                    begin
                        data_we = 1'b1;
                        st_next = oaht_pkg::ST_UPDATED;
                    end
                    else if (op_reg == oaht_pkg::OP_DELETE)
                    begin
                        dout_next = d_rd;
                        mark_we   = 1'b1;
                        w_mark    = oaht_pkg::MARK_GONE;
                        occ_next  = occ_reg - 17'd1;
                        st_next   = oaht_pkg::ST_DELETED;
                    end
                    else
                    begin
                        dout_next = d_rd;
                        st_next   = oaht_pkg::ST_FOUND;
                    end
                end
                else
                begin
                    if (m_rd == oaht_pkg::MARK_GONE && !gone_reg)
                    begin
                        gone_next  = 1'b1;
                        first_next = idx_reg;
                    end
                    idx_next = idx_wrap;
                    if (idx_wrap == home_reg)
                    begin
                        // full circle: reuse the first deleted slot seen
                        if (is_ins && (gone_reg || m_rd == oaht_pkg::MARK_GONE))
                        begin
                            mark_we = 1'b1;
                            kd_we   = 1'b1;
                            data_we = 1'b1;
                            w_addr  = gone_reg ? first_reg : idx_reg;
                            w_kaddr = w_addr;
                            w_mark  = oaht_pkg::MARK_USED;
                            occ_next = occ_reg + 17'd1;
                            st_next = oaht_pkg::ST_INSERTED;
                        end
                    end
                    else
                        state_next = S_RD;
                end
            end
            S_OUT:
            begin
                if (res_take) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            idx_reg   <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gone_reg   <= gone_next;
        first_reg  <= first_next;
        probes_reg <= probes_next;
        st_reg     <= st_next;
        dout_reg   <= dout_next;
        if (q_pop)
        begin
            home_reg <= AW'(q_data.home);
            step_reg <= {1'b0, q_data.step};
            op_reg   <= q_data.op;
            key_reg  <= KEY_BITS'(q_data.key);
            din_reg  <= DATA_BITS'(q_data.data);
            full_reg <= (occ_reg + 17'd1) >= size;
        end
    end

    assign res_valid  = state_reg == S_OUT;
    assign res_status = st_reg;
    assign res_data   = dout_reg;
    assign res_probes = 11'(probes_reg);
    assign res_count  = 10'(occ_reg);
    assign clearing   = state_reg == S_CLR;
endmodule

`default_nettype wire

@@ hdl/open_address_hash_table_unit.sv @@
// ============================================================================
// open_address_hash_table_unit: open-addressing hash table
// Search, insert and delete requests over a slot table with probe marks.
// ============================================================================
// Requests enter through push/full, one beat per request; results leave
// through empty/pop, one beat per request, in request order.
// The front end reduces home slot and step modulo the live size by repeated
// subtraction, both in parallel, one subtract per cycle. It then queues the
// request in a two-entry queue and can accept the next one.
// The probe engine picks a request from the queue, examines one slot at a
// time (memory read, then compare) and then shows the result until it is
// popped; the unused op code goes straight to the result.
// Reset: the size register returns to 1024 and probing to linear; the engine
// then clears every slot mark, one slot per cycle, with full high. Write
// configuration only while no request is in flight.
// While a result waits unpopped the engine holds; the front end keeps
// accepting until its queue is full, so at most four requests sit inside.
// ============================================================================
`default_nettype none

module open_address_hash_table_unit #(
    parameter int SLOTS = 1024,
    parameter int KEY_BITS = 64,
    parameter int DATA_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           op,
    input  wire logic [KEY_BITS-1:0]  key,
    input  wire logic [DATA_BITS-1:0] data_in,
    input  wire logic [9:0]           home_slot,
    input  wire logic [9:0]           probe_step,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [2:0]                status,
    output logic [DATA_BITS-1:0]      data_out,
    output logic [10:0]               probe_count,
    output logic [9:0]                entry_count
);
    logic [10:0] size_reg;
    logic        mode_reg;
    logic [16:0] live;
    logic        wr;
    logic        front_full, clearing;
    oaht_pkg::req_t q_data;
    logic        q_valid, q_pop, res_valid;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 11'd1024;
            mode_reg <= 1'b0;
        end
        else if (wr)
        begin
            if (paddr[2] == oaht_pkg::REG_SIZE[0]) size_reg <= pwdata[10:0];
            else mode_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == oaht_pkg::REG_PROBE_MODE[0]) prdata[0] = mode_reg;
        else prdata[10:0] = size_reg;
    end

    always_comb
    begin
        priority if (size_reg < 11'd2) live = 17'd2;
        else if (32'(size_reg) > SLOTS) live = 17'(SLOTS);
        else live = 17'(size_reg);
    end

    assign full = front_full || clearing;

    oaht_front #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push && !clearing), .full(front_full),
        .op(op), .key(key), .data_in(data_in), .home_slot(home_slot),
        .probe_step(probe_step), .size(live), .mode(mode_reg),
        .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
    );

    oaht_engine #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS)) u_engine (
        .clk(clk), .rst_n(rst_n), .size(live), .q_data(q_data), .q_valid(q_valid),
        .q_pop(q_pop), .res_valid(res_valid), .res_take(pop),
        .res_status(status), .res_data(data_out), .res_probes(probe_count),
        .res_count(entry_count), .clearing(clearing)
    );

    assign empty = !res_valid;

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> full) else $error("request taken during clear");
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(probe_count)))
        else $error("result dropped");
    a_probe_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != oaht_pkg::ST_MISSING) |-> probe_count != 11'd0)
        else $error("result without probe");
endmodule

`default_nettype wire

@@ dv/tb_open_address_hash_table_unit.sv @@
// ============================================================================
// tb_open_address_hash_table_unit: self-checking bench for the hash table
// Drives search, insert and delete requests through the queue-style ports
// and compares every result beat against a behavioral copy of the table.
// Both sides idle at random, and the table is programmed over APB between
// phases.
// ============================================================================
`timescale 1ns / 100ps

module tb_open_address_hash_table_unit;

    localparam int          NSLOTS    = 1024;
    localparam int          KEY_POOL  = 24;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data_out;
        logic [10:0] probe_count;
        logic [9:0]  entry_count;
    } table_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  op = '0;
    logic [63:0] key = '0;
    logic [31:0] data_in = '0;
    logic [9:0]  home_slot = '0;
    logic [9:0]  probe_step = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  status;
    logic [31:0] data_out;
    logic [10:0] probe_count;
    logic [9:0]  entry_count;

    open_address_hash_table_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .op(op), .key(key), .data_in(data_in),
        .home_slot(home_slot), .probe_step(probe_step),
        .empty(empty), .pop(pop), .status(status), .data_out(data_out),
        .probe_count(probe_count), .entry_count(entry_count)
    );

    // table shadow
    logic [1:0]  mark_mem [NSLOTS];
    logic [63:0] key_mem [NSLOTS];
    logic [31:0] data_mem [NSLOTS];
    int unsigned occupied;
    logic [10:0] cfg_size = 11'd1024;
    logic        cfg_double = 1'b0;

    table_result_t pending_results [$];
    logic [63:0]   key_pool [KEY_POOL];

    int  req_count = 0;
    int  result_count = 0;
    int  fail_count = 0;
    bit  tx_quiet = 0;
    bit  rx_quiet = 0;
    int  rx_hold = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #300ms;
        $display("tb_open_address_hash_table_unit NOT OK");
        $finish;
    end

    // work out the result of one request and update the shadow table
    task automatic table_apply(input logic [1:0] rop, input logic [63:0] rkey,
                               input logic [31:0] rdin, input logic [9:0] rhome,
                               input logic [9:0] rstep);
        int unsigned size, home, step, idx, probes, first_gone, dst;
        bit is_full, seen_gone, done;
        table_result_t r;
        size = (cfg_size < 2) ? 2 : (cfg_size > NSLOTS) ? NSLOTS : cfg_size;
        home = rhome % size;
        step = 1;
        if (cfg_double)
        begin
            step = rstep % size;
            if (step == 0)
                step = 1;
        end
        r.status = oaht_pkg::ST_MISSING;
        r.data_out = '0;
        probes = 0;
        if (rop != oaht_pkg::OP_NONE)
        begin
            idx = home;
            is_full = (occupied + 1 >= size);
            seen_gone = 0;
            first_gone = 0;
            done = 0;
            if (rop == oaht_pkg::OP_INSERT)
                r.status = oaht_pkg::ST_FAILED;
            while (!done)
            begin
                probes++;
                if (mark_mem[idx] == oaht_pkg::MARK_EMPTY)
                begin
                    if (rop == oaht_pkg::OP_INSERT && (!is_full || seen_gone))
                    begin
                        dst = seen_gone ? first_gone : idx;
                        key_mem[dst] = rkey;
                        data_mem[dst] = rdin;
                        mark_mem[dst] = oaht_pkg::MARK_USED;
                        occupied++;
                        r.status = oaht_pkg::ST_INSERTED;
                    end
                    break;
                end
                if (mark_mem[idx] == oaht_pkg::MARK_USED && key_mem[idx] == rkey)
                begin
                    if (rop == oaht_pkg::OP_INSERT)
                    begin
                        data_mem[idx] = rdin;
                        r.status = oaht_pkg::ST_UPDATED;
                    end
                    else if (rop == oaht_pkg::OP_DELETE)
                    begin
                        r.data_out = data_mem[idx];
                        mark_mem[idx] = oaht_pkg::MARK_GONE;
                        occupied--;
                        r.status = oaht_pkg::ST_DELETED;
                    end
                    else
                    begin
                        r.data_out = data_mem[idx];
                        r.status = oaht_pkg::ST_FOUND;
                    end
                    break;
                end
                if (mark_mem[idx] == oaht_pkg::MARK_GONE && !seen_gone)
                begin
                    seen_gone = 1;
                    first_gone = idx;
                end
                idx = (idx >= step) ? idx - step : idx + size - step;
                if (idx == home)
                begin
                    if (rop == oaht_pkg::OP_INSERT && seen_gone)
                    begin
                        key_mem[first_gone] = rkey;
                        data_mem[first_gone] = rdin;
                        mark_mem[first_gone] = oaht_pkg::MARK_USED;
                        occupied++;
                        r.status = oaht_pkg::ST_INSERTED;
                    end
                    done = 1;
                end
            end
        end
        r.probe_count = probes[10:0];
        r.entry_count = occupied[9:0];
        pending_results.push_back(r);
    endtask

    // offer one request beat; push stays high on return
    task automatic send_request(input logic [1:0] rop, input logic [63:0] rkey,
                                input logic [31:0] rdin, input logic [9:0] rhome,
                                input logic [9:0] rstep);
        int gap;
        bit taken;
        gap = tx_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        op <= rop;
        key <= rkey;
        data_in <= rdin;
        home_slot <= rhome;
        probe_step <= rstep;
        do
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        while (!taken);
        table_apply(rop, rkey, rdin, rhome, rstep);
        req_count++;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        wait (pending_results.size() == 0);
        // let the engine settle before touching registers
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index[0], 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == oaht_pkg::REG_SIZE)
            cfg_size = value[10:0];
        else
            cfg_double = value[0];
    endtask

    task automatic configure(input logic [31:0] size, input logic [31:0] mode);
        drain_results();
        write_reg(oaht_pkg::REG_SIZE, size);
        write_reg(oaht_pkg::REG_PROBE_MODE, mode);
    endtask

    task automatic new_key_pool();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = {$urandom, $urandom};
    endtask

    task automatic random_request(input int key_span);
        int pick;
        logic [1:0] rop;
        pick = $urandom_range(0, 99);
        rop = (pick < 40) ? oaht_pkg::OP_INSERT : (pick < 70) ? oaht_pkg::OP_SEARCH :
              (pick < 96) ? oaht_pkg::OP_DELETE : oaht_pkg::OP_NONE;
        send_request(rop, key_pool[$urandom_range(0, key_span - 1)], $urandom,
                     10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    endtask

    // result checker
    initial begin
        table_result_t want, got;
        int stall;
        bit seen;
        forever
        begin
            if (rx_hold > 0)
            begin
                pop <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            stall = rx_quiet ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(negedge clk);
            seen = !empty;
            got = '{status, data_out, probe_count, entry_count};
            @(posedge clk);
            if (seen)
            begin
                result_count++;
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.data_out !== want.data_out)
                    begin
                        $error("data_out: expected %h, got %h", want.data_out, got.data_out);
                        fail_count++;
                    end
                    if (got.probe_count !== want.probe_count)
                    begin
                        $error("probe_count: expected %0d, got %0d",
                               want.probe_count, got.probe_count);
                        fail_count++;
                    end
                    if (got.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        fail_count++;
                    end
                end
            end
        end
    end

    // basic ops at reset settings, field extremes, unused op, update, delete
    task automatic test_directed();
        send_request(oaht_pkg::OP_INSERT, '0, '0, 10'd0, 10'd1);
        send_request(oaht_pkg::OP_INSERT, '1, '1, 10'd1023, 10'd1023);
        send_request(oaht_pkg::OP_INSERT, 64'h1, 32'h5a5a_a5a5, 10'd0, 10'd1);
        send_request(oaht_pkg::OP_SEARCH, '0, '1, 10'd0, 10'd0);
        send_request(oaht_pkg::OP_SEARCH, '1, '0, 10'd1023, 10'd0);
        send_request(oaht_pkg::OP_SEARCH, 64'h1, '0, 10'd0, 10'd0);
        send_request(oaht_pkg::OP_INSERT, '1, 32'h1234_5678, 10'd1023, 10'd1);
        send_request(oaht_pkg::OP_SEARCH, '1, '0, 10'd1023, 10'd1);
        send_request(oaht_pkg::OP_DELETE, '0, '1, 10'd0, 10'd1);
        send_request(oaht_pkg::OP_SEARCH, 64'h1, '0, 10'd0, 10'd1);
        send_request(oaht_pkg::OP_DELETE, 64'h2, '0, 10'd5, 10'd1);
        send_request(oaht_pkg::OP_NONE, '1, '1, 10'd1023, 10'd1023);
        send_request(oaht_pkg::OP_INSERT, 64'h2, 32'h0000_0001, 10'd0, 10'd1);
        send_request(oaht_pkg::OP_SEARCH, 64'h2, '0, 10'd0, 10'd1);
    endtask

    // size below minimum acts as two and above maximum as 1024; fill, fail, reuse a deleted slot
    task automatic test_tiny_table();
        configure(32'd0, 32'd0);
        send_request(oaht_pkg::OP_INSERT, 64'hdead, 32'h11, 10'd3, 10'd0);
        send_request(oaht_pkg::OP_INSERT, 64'hbeef, 32'h22, 10'd3, 10'd0);
        send_request(oaht_pkg::OP_DELETE, 64'hdead, '0, 10'd3, 10'd0);
        send_request(oaht_pkg::OP_INSERT, 64'hbeef, 32'h33, 10'd3, 10'd0);
        send_request(oaht_pkg::OP_SEARCH, 64'hbeef, '0, 10'd2, 10'd0);
        configure(32'd1, 32'd1);
        for (int i = 0; i < 12; i++)
            random_request(4);
        configure(32'd2047, 32'd1);
        send_request(oaht_pkg::OP_INSERT, 64'h77, 32'h44, 10'd1023, 10'd0);
        send_request(oaht_pkg::OP_SEARCH, 64'h77, '0, 10'd1023, 10'd0);
    endtask

    // steps sharing a factor with the size stop before a full circle
    task automatic test_short_cycle();
        configure(32'd12, 32'd1);
        for (int i = 0; i < 30; i++)
            send_request((i % 3 == 2) ? oaht_pkg::OP_SEARCH : oaht_pkg::OP_INSERT,
                         key_pool[i % KEY_POOL], $urandom, 10'(i * 5),
                         (i % 2) ? 10'd4 : 10'd6);
    endtask

    task automatic test_random_phases();
        logic [31:0] sizes [8] = '{32'd2, 32'd8, 32'd37, 32'd64, 32'd200, 32'd1024,
                                   32'd5, 32'd2047};
        for (int p = 0; p < 8; p++)
        begin
            configure(sizes[p], p % 2);
            new_key_pool();
            for (int i = 0; i < 150; i++)
            begin
                if (i % 50 == 0)
                begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                random_request(KEY_POOL);
            end
            tx_quiet = 0;
            rx_quiet = 0;
        end
    endtask

    // hold the result side off so the input side stalls on full
    task automatic test_backpressure();
        configure(32'd64, 32'd0);
        tx_quiet = 1;
        rx_hold = 400;
        for (int i = 0; i < 60; i++)
            random_request(KEY_POOL);
        tx_quiet = 0;
    endtask

    initial begin
        for (int i = 0; i < NSLOTS; i++)
        begin
            mark_mem[i] = oaht_pkg::MARK_EMPTY;
            key_mem[i] = '0;
            data_mem[i] = '0;
        end
        occupied = 0;
        new_key_pool();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_tiny_table();
        test_short_cycle();
        test_random_phases();
        test_backpressure();
        drain_results();
        $display("Ran %0d requests, checked %0d results over several sizes and both probe modes",
                 req_count, result_count);
        if (fail_count == 0)
            $display("tb_open_address_hash_table_unit OK");
        else
            $display("tb_open_address_hash_table_unit NOT OK");
        $finish;
    end

endmodule

@@ open_address_hash_table_unit.f @@
hdl/oaht_pkg.sv
hdl/oaht_front.sv
hdl/oaht_engine.sv
hdl/open_address_hash_table_unit.sv
dv/tb_open_address_hash_table_unit.sv
